// ===== rtl/qu2x_pkg.sv =====
`default_nettype none

package qu2x_pkg;

  // Map geometry
  localparam int RES      = 33;
  localparam int HALF_RES = RES / 2;
  localparam int CRD_W    = 6;
  localparam int COMP_W   = 16;
  localparam int NCOMP    = 4;
  localparam int TEXEL_W  = NCOMP * COMP_W;

  // Each parity bank holds the texels of one (row parity, column parity) class
  localparam int HALF_W   = $clog2(RES / 2 + 2);
  localparam int BANK_AW  = 2 * HALF_W;
  localparam int NBANK    = 4;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    QUAD_TL = 2'd0,
    QUAD_TR = 2'd1,
    QUAD_BR = 2'd2,
    QUAD_BL = 2'd3
  } quad_e;

  typedef logic [NCOMP-1:0][COMP_W-1:0] texel_t;
  typedef texel_t [NBANK-1:0] bank_rd_t;

  // Selection info handed from the read stage to the filter
  typedef struct packed {
    logic row_par;
    logic col_par;
    logic row_odd;
    logic col_odd;
  } sel_t;

  // Floor of the mean of two signed components, exact at one extra bit
  function automatic logic [COMP_W-1:0] avg2(input logic [COMP_W-1:0] a,
                                             input logic [COMP_W-1:0] b);
    logic [COMP_W:0] sum;
    sum = {a[COMP_W-1], a} + {b[COMP_W-1], b};
    return sum[COMP_W:1];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qu2x_if.sv =====
`default_nettype none

interface qu2x_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  operation;
  logic [1:0]                            quadrant;
  logic [qu2x_pkg::CRD_W-1:0]            row;
  logic [qu2x_pkg::CRD_W-1:0]            col;
  logic signed [qu2x_pkg::COMP_W-1:0]    in_comp0;
  logic signed [qu2x_pkg::COMP_W-1:0]    in_comp1;
  logic signed [qu2x_pkg::COMP_W-1:0]    in_comp2;
  logic signed [qu2x_pkg::COMP_W-1:0]    in_comp3;

  modport source (output valid, operation, quadrant, row, col,
                  in_comp0, in_comp1, in_comp2, in_comp3,
                  input ready);
  modport sink (input valid, operation, quadrant, row, col,
                in_comp0, in_comp1, in_comp2, in_comp3,
                output ready);
endinterface

interface qu2x_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [qu2x_pkg::COMP_W-1:0]    out_comp0;
  logic signed [qu2x_pkg::COMP_W-1:0]    out_comp1;
  logic signed [qu2x_pkg::COMP_W-1:0]    out_comp2;
  logic signed [qu2x_pkg::COMP_W-1:0]    out_comp3;

  modport source (output valid, out_comp0, out_comp1, out_comp2, out_comp3,
                  input ready);
  modport sink (input valid, out_comp0, out_comp1, out_comp2, out_comp3,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/qu2x_bank.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module qu2x_bank #(
  parameter int AW = 10,
  parameter int DW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, hold data when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/qu2x_filter.sv =====
`default_nettype none

// Route the four parity-bank words to their neighbor roles and average
module qu2x_filter (
  input  wire qu2x_pkg::bank_rd_t rd_i,
  input  wire qu2x_pkg::sel_t     sel_i,
  output qu2x_pkg::texel_t        texel_o
);

  logic [1:0]       idx_a, idx_b, idx_c, idx_d;
  qu2x_pkg::texel_t ta, tb, tc, td;

  // Pick the texel at (r,c), (r,c+1), (r+1,c) and (r+1,c+1)
  always_comb begin
    idx_a = {sel_i.row_par, sel_i.col_par};
    idx_b = {sel_i.row_par, ~sel_i.col_par};
    idx_c = {~sel_i.row_par, sel_i.col_par};
    idx_d = {~sel_i.row_par, ~sel_i.col_par};
    ta    = rd_i[idx_a];
    tb    = rd_i[idx_b];
    tc    = rd_i[idx_c];
    td    = rd_i[idx_d];
  end

  // Average along the row, then down the column
  always_comb begin
    logic [qu2x_pkg::COMP_W-1:0] top, bot;
    for (int k = 0; k < qu2x_pkg::NCOMP; k++) begin
      top = sel_i.col_odd ? qu2x_pkg::avg2(ta[k], tb[k]) : ta[k];
      bot = sel_i.col_odd ? qu2x_pkg::avg2(tc[k], td[k]) : tc[k];
      texel_o[k] = sel_i.row_odd ? qu2x_pkg::avg2(top, bot) : top;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quadrant_upsample_2x.sv =====
// A query is read from the parity banks into the read stage, then filtered into the
// output register, from which it is handed off when out_if.ready is high.
// Throughput: one word per cycle while the output is not stalled, loads and queries alike; loads give no result.
// Four parity banks each serve one of the four neighbor texels in one read.
// Reset (rst_ni low, asynchronous) clears the pipeline and output valids.
// The texel memory is not cleared; entries read before written are undefined.
`default_nettype none

module quadrant_upsample_2x (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qu2x_in_if.sink     in_if,
  qu2x_out_if.source  out_if
);

  logic in_acc, in_range, is_load, is_query;
  logic advance;

  logic [qu2x_pkg::CRD_W-1:0] r0, c0, sr, sc;
  logic [qu2x_pkg::TEXEL_W-1:0] wdata;

  logic [qu2x_pkg::NBANK-1:0]                    bank_we;
  logic [qu2x_pkg::NBANK-1:0][qu2x_pkg::BANK_AW-1:0] bank_raddr;
  logic [qu2x_pkg::BANK_AW-1:0]                  bank_waddr;
  qu2x_pkg::bank_rd_t                            bank_rd;

  logic             s1_valid_q, s1_valid_d;
  qu2x_pkg::sel_t   sel_q, sel_d;
  logic             out_valid_q, out_valid_d;
  qu2x_pkg::texel_t out_q, out_d, filt;

  // Decode the incoming word
  always_comb begin
    in_acc   = in_if.valid && in_if.ready;
    in_range = (in_if.row < qu2x_pkg::CRD_W'(qu2x_pkg::RES)) &&
               (in_if.col < qu2x_pkg::CRD_W'(qu2x_pkg::RES));
    is_load  = in_acc && in_range && (in_if.operation == qu2x_pkg::OP_LOAD);
    is_query = in_acc && in_range && (in_if.operation == qu2x_pkg::OP_QUERY);
  end

  // Source coordinates of the top-left neighbor
  always_comb begin
    r0 = ((in_if.quadrant == qu2x_pkg::QUAD_BR) || (in_if.quadrant == qu2x_pkg::QUAD_BL))
         ? qu2x_pkg::CRD_W'(qu2x_pkg::HALF_RES) : '0;
    c0 = ((in_if.quadrant == qu2x_pkg::QUAD_TR) || (in_if.quadrant == qu2x_pkg::QUAD_BR))
         ? qu2x_pkg::CRD_W'(qu2x_pkg::HALF_RES) : '0;
    sr = r0 + (in_if.row >> 1);
    sc = c0 + (in_if.col >> 1);
  end

  // Bank addresses: each bank gets the neighbor of its own parity
  always_comb begin
    logic [qu2x_pkg::CRD_W-1:0] rp, cp;
    wdata      = {in_if.in_comp3, in_if.in_comp2, in_if.in_comp1, in_if.in_comp0};
    bank_waddr = {qu2x_pkg::HALF_W'(in_if.row >> 1), qu2x_pkg::HALF_W'(in_if.col >> 1)};
    for (int b = 0; b < qu2x_pkg::NBANK; b++) begin
      rp = sr + qu2x_pkg::CRD_W'(sr[0] != b[1]);
      cp = sc + qu2x_pkg::CRD_W'(sc[0] != b[0]);
      bank_raddr[b] = {qu2x_pkg::HALF_W'(rp >> 1), qu2x_pkg::HALF_W'(cp >> 1)};
      bank_we[b]    = is_load && (in_if.row[0] == b[1]) && (in_if.col[0] == b[0]);
    end
  end

  // Parity banks
  for (genvar g = 0; g < qu2x_pkg::NBANK; g++) begin : g_bank
    qu2x_bank #(
      .AW (qu2x_pkg::BANK_AW),
      .DW (qu2x_pkg::TEXEL_W)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .waddr_i (bank_waddr),
      .wdata_i (wdata),
      .re_i    (is_query),
      .raddr_i (bank_raddr[g]),
      .rdata_o (bank_rd[g])
    );
  end

  qu2x_filter u_filter (
    .rd_i    (bank_rd),
    .sel_i   (sel_q),
    .texel_o (filt)
  );

  // Handshake: take a word whenever the read stage can move on
  assign advance     = !out_valid_q || out_if.ready;
  assign in_if.ready = !s1_valid_q || advance;

  // Next state of read stage and output register
  always_comb begin
    s1_valid_d  = s1_valid_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      s1_valid_d  = 1'b0;
      out_valid_d = s1_valid_q;
      if (s1_valid_q) begin
        out_d = filt;
      end
    end
    if (in_acc) begin
      s1_valid_d = is_query;
      sel_d      = '{row_par: sr[0], col_par: sc[0],
                     row_odd: in_if.row[0], col_odd: in_if.col[0]};
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    out_q <= out_d;
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.out_comp0 = out_q[0];
  assign out_if.out_comp1 = out_q[1];
  assign out_if.out_comp2 = out_q[2];
  assign out_if.out_comp3 = out_q[3];

endmodule

`default_nettype wire

// ===== rtl/qu2x_checker.sv =====
`default_nettype none

module qu2x_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_valid_i,
  input wire logic                           in_ready_i,
  input wire logic                           in_op_i,
  input wire logic [qu2x_pkg::CRD_W-1:0]     in_row_i,
  input wire logic [qu2x_pkg::CRD_W-1:0]     in_col_i,
  input wire logic                           out_valid_i,
  input wire logic                           out_ready_i,
  input wire logic [qu2x_pkg::COMP_W-1:0]    out_comp0_i,
  input wire logic [qu2x_pkg::COMP_W-1:0]    out_comp1_i,
  input wire logic [qu2x_pkg::COMP_W-1:0]    out_comp2_i,
  input wire logic [qu2x_pkg::COMP_W-1:0]    out_comp3_i
);

  logic query_ok;

  assign query_ok = in_valid_i && in_ready_i &&
                    (in_op_i == qu2x_pkg::OP_QUERY) &&
                    (in_row_i < qu2x_pkg::CRD_W'(qu2x_pkg::RES)) &&
                    (in_col_i < qu2x_pkg::CRD_W'(qu2x_pkg::RES));

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_comp0_i) && $stable(out_comp1_i) &&
                                    $stable(out_comp2_i) && $stable(out_comp3_i))
    else $error("stalled result changed");

  // A fresh result comes only from an accepted in-range query
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(query_ok, 2))
    else $error("result without a matching query");

  // An empty output never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind quadrant_upsample_2x qu2x_checker u_qu2x_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_op_i     (in_if.operation),
  .in_row_i    (in_if.row),
  .in_col_i    (in_if.col),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_comp0_i (out_if.out_comp0),
  .out_comp1_i (out_if.out_comp1),
  .out_comp2_i (out_if.out_comp2),
  .out_comp3_i (out_if.out_comp3)
);

`default_nettype wire

// ===== dv/quadrant_upsample_2x_test.sv =====
`timescale 1ns / 100ps

module quadrant_upsample_2x_test;
  import qu2x_pkg::*;

  localparam int ITEM_TARGET = 450;
  localparam int HOLD_AT     = 120;
  localparam int DRAIN_AT    = 250;
  localparam int CALM_FROM   = 370;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 10;
  localparam int MAX_PRINTS  = 60;
  localparam int CRD_MAX     = (1 << CRD_W) - 1;

  localparam logic [COMP_W-1:0] MAX_POS = 16'h7fff;
  localparam logic [COMP_W-1:0] MIN_NEG = 16'h8000;

  // How a word's expected result is obtained
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TEXEL,
    CHK_NONE
  } chk_e;

  typedef struct {
    op_e              op;
    quad_e            quad;
    logic [CRD_W-1:0] row;
    logic [CRD_W-1:0] col;
    texel_t           data;
    chk_e             chk;
    texel_t           want;
  } word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  qu2x_in_if  in_if ();
  qu2x_out_if out_if ();

  quadrant_upsample_2x dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the source map
  texel_t src_map [RES][RES];
  bit     loaded  [RES][RES];

  texel_t pending_texels [$];
  int     err_count    = 0;
  int     words_sent   = 0;
  int     stall_cycles = 0;
  bit     calm         = 1'b0;
  bit     hold_req     = 1'b0;

  task automatic report_mismatch(string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  function automatic texel_t tx(int c0, int c1, int c2, int c3);
    return {COMP_W'(c3), COMP_W'(c2), COMP_W'(c1), COMP_W'(c0)};
  endfunction

  function automatic logic [COMP_W-1:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return MAX_POS;
      1: return MIN_NEG;
      default: return COMP_W'($urandom);
    endcase
  endfunction

  function automatic texel_t rand_texel();
    return {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return RES - 1;
      default: return $urandom_range(0, RES - 1);
    endcase
  endfunction

  function automatic word_t mk_word(op_e op, quad_e q, int r, int c, texel_t d,
                                    chk_e chk = CHK_MODEL, texel_t want = '0);
    word_t w;
    w.op   = op;
    w.quad = q;
    w.row  = CRD_W'(r);
    w.col  = CRD_W'(c);
    w.data = d;
    w.chk  = chk;
    w.want = want;
    return w;
  endfunction

  // Quadrant origin in the source map
  function automatic int quad_row0(quad_e q);
    return (q == QUAD_BR || q == QUAD_BL) ? HALF_RES : 0;
  endfunction

  function automatic int quad_col0(quad_e q);
    return (q == QUAD_TR || q == QUAD_BR) ? HALF_RES : 0;
  endfunction

  // Floor of the mean of two signed components
  function automatic logic [COMP_W-1:0] mean_floor(logic signed [COMP_W-1:0] a,
                                                   logic signed [COMP_W-1:0] b);
    logic signed [COMP_W:0] sum;
    sum = a + b;
    return COMP_W'(sum >>> 1);
  endfunction

  // One component of a source row, blended across columns when needed
  function automatic logic [COMP_W-1:0] row_mix(int sr, int sc, bit odd_col, int k);
    if (odd_col) return mean_floor(src_map[sr][sc][k], src_map[sr][sc+1][k]);
    return src_map[sr][sc][k];
  endfunction

  function automatic texel_t upsample_at(quad_e q, int r, int c);
    texel_t res;
    int     sr;
    int     sc;
    sr = quad_row0(q) + r / 2;
    sc = quad_col0(q) + c / 2;
    for (int k = 0; k < NCOMP; k++) begin
      res[k] = row_mix(sr, sc, c % 2 == 1, k);
      if (r % 2 == 1) res[k] = mean_floor(res[k], row_mix(sr + 1, sc, c % 2 == 1, k));
    end
    return res;
  endfunction

  // Drop valid for a random burst now and then
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Offer one word, hold it until taken, then update the shadow state
  task automatic send_word(word_t w);
    in_if.valid     <= 1'b1;
    in_if.operation <= w.op;
    in_if.quadrant  <= w.quad;
    in_if.row       <= w.row;
    in_if.col       <= w.col;
    in_if.in_comp0  <= w.data[0];
    in_if.in_comp1  <= w.data[1];
    in_if.in_comp2  <= w.data[2];
    in_if.in_comp3  <= w.data[3];
    do @(posedge clk_i); while (!in_if.ready);

    words_sent++;
    if (w.op == OP_LOAD) begin
      if (w.row < RES && w.col < RES) begin
        src_map[w.row][w.col] = w.data;
        loaded[w.row][w.col]  = 1'b1;
      end
    end else if (w.chk == CHK_TEXEL) begin
      pending_texels.push_back(w.want);
    end else if (w.chk == CHK_MODEL && w.row < RES && w.col < RES) begin
      pending_texels.push_back(upsample_at(w.quad, w.row, w.col));
    end
  endtask

  // Load every source texel a query will read that is not yet written
  task automatic prime_sources(quad_e q, int r, int c);
    int sr;
    int sc;
    sr = quad_row0(q) + r / 2;
    sc = quad_col0(q) + c / 2;
    for (int dr = 0; dr <= r % 2; dr++) begin
      for (int dc = 0; dc <= c % 2; dc++) begin
        if (!loaded[sr+dr][sc+dc]) begin
          sender_gap();
          send_word(mk_word(OP_LOAD, quad_e'($urandom_range(0, 3)), sr + dr, sc + dc,
                            rand_texel()));
        end
      end
    end
  endtask

  // Stimulus
  initial begin
    word_t  steer_tab [$];
    texel_t corner_a;
    quad_e  q;
    int     r;
    int     c;
    bit     held;
    bit     drained;

    held    = 1'b0;
    drained = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.operation <= OP_LOAD;
    in_if.quadrant  <= QUAD_TL;
    in_if.row       <= '0;
    in_if.col       <= '0;
    in_if.in_comp0  <= '0;
    in_if.in_comp1  <= '0;
    in_if.in_comp2  <= '0;
    in_if.in_comp3  <= '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every quadrant corner, out-of-range words
    corner_a = tx(MAX_POS, MIN_NEG, 0, -1);
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_TL, 0, 0, corner_a));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_TL, 0, 1, tx(MAX_POS, MIN_NEG, 1, 0)));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_TL, 1, 0, tx(MIN_NEG, MAX_POS, 0, 0)));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_TL, 1, 1, tx(MIN_NEG, MAX_POS, -1, -1)));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TL, 0, 0, '0, CHK_TEXEL, corner_a));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TL, 0, 1, '0));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TL, 1, 0, '0));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TL, 1, 1, '1));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_BR, RES - 1, RES - 1,
                                tx(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG)));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_BR, RES - 1, RES - 1, '0, CHK_TEXEL,
                                tx(MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG)));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_TR, 0, RES - 1,
                                tx(MAX_POS, MAX_POS, MAX_POS, MAX_POS)));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TR, 0, RES - 1, '0, CHK_TEXEL,
                                tx(MAX_POS, MAX_POS, MAX_POS, MAX_POS)));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_BL, RES - 1, 0,
                                tx(21845, -21846, 21845, -21846)));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_BL, RES - 1, 0, '0, CHK_TEXEL,
                                tx(21845, -21846, 21845, -21846)));
    // Loads outside the map must not land anywhere
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_BL, RES, 0, tx(1, 2, 3, 4)));
    steer_tab.push_back(mk_word(OP_LOAD,  QUAD_BR, 0, CRD_MAX, tx(-1, -2, -3, -4)));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TL, 0, 0, '0, CHK_TEXEL, corner_a));
    // Queries outside the grid give no result
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TL, RES, 0, '0, CHK_NONE));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_BR, 0, CRD_MAX, '0, CHK_NONE));
    steer_tab.push_back(mk_word(OP_QUERY, QUAD_TR, CRD_MAX, CRD_MAX, '1, CHK_NONE));

    foreach (steer_tab[i]) begin
      sender_gap();
      send_word(steer_tab[i]);
    end

    // Random: mostly queries over written texels, with loads and stray words mixed in
    while (words_sent < ITEM_TARGET) begin
      if (words_sent >= CALM_FROM) calm = 1'b1;
      if (!held && words_sent >= HOLD_AT) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && words_sent >= DRAIN_AT) begin
        drained = 1'b1;
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_texels.size() != 0);
      end

      q = quad_e'($urandom_range(0, 3));
      case ($urandom_range(0, 19))
        13, 14, 15, 16: begin
          sender_gap();
          send_word(mk_word(OP_LOAD, q, rand_coord(), rand_coord(), rand_texel()));
        end
        17, 18: begin
          r = rand_coord();
          c = rand_coord();
          case ($urandom_range(0, 2))
            0: r = $urandom_range(RES, CRD_MAX);
            1: c = $urandom_range(RES, CRD_MAX);
            default: begin
              r = $urandom_range(RES, CRD_MAX);
              c = $urandom_range(RES, CRD_MAX);
            end
          endcase
          sender_gap();
          send_word(mk_word(OP_QUERY, q, r, c, rand_texel()));
        end
        19: begin
          sender_gap();
          send_word(mk_word(OP_LOAD, q, $urandom_range(RES, CRD_MAX),
                            $urandom_range(0, CRD_MAX), rand_texel()));
        end
        default: begin
          r = rand_coord();
          c = rand_coord();
          prime_sources(q, r, c);
          sender_gap();
          send_word(mk_word(OP_QUERY, q, r, c, rand_texel()));
        end
      endcase
    end

    // Drain and let the pipeline settle
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_texels.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare each delivered word against the oldest expectation
  always @(posedge clk_i) begin
    texel_t got;
    texel_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.out_comp3, out_if.out_comp2, out_if.out_comp1, out_if.out_comp0};
      if (pending_texels.size() == 0) begin
        report_mismatch($sformatf("result %h with no query waiting", got));
      end else begin
        want = pending_texels.pop_front();
        for (int k = 0; k < NCOMP; k++) begin
          if (got[k] !== want[k]) begin
            report_mismatch($sformatf("out_comp%0d got %h expected %h", k, got[k], want[k]));
          end
        end
      end
    end
  end

  // Stop the run if no word moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no word moved for %0d cycles, %0d results outstanding",
               $time, stall_cycles, pending_texels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
rtl/qu2x_pkg.sv
rtl/qu2x_if.sv
rtl/qu2x_bank.sv
rtl/qu2x_filter.sv
rtl/quadrant_upsample_2x.sv
rtl/qu2x_checker.sv
dv/quadrant_upsample_2x_test.sv
